FILE: rtl/gps_pkg.sv
package gps_pkg;

  // frame layout: header 001, 16-bit value, even parity
  localparam int POS_W       = 16;
  localparam int FRAME_BITS  = 20;
  localparam int BEATS       = 2 * FRAME_BITS;
  localparam int BEAT_W      = $clog2(BEATS);
  localparam int PIN_W       = 8;

  localparam logic [2:0]        FRAME_HEADER = 3'b001;
  localparam logic [POS_W-1:0]  SIGN_OFFSET  = 16'h8000;
  localparam logic [BEAT_W-1:0] LAST_BEAT    = BEAT_W'(BEATS - 1);
  // first beat of the parity bit, where sync drops
  localparam logic [BEAT_W-1:0] PARITY_BEAT  = BEAT_W'(BEATS - 2);

  typedef struct packed {
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin_levels;
    logic             last;
  } out_item_t;

  // per-beat control from the sequencer to the merge stage
  typedef struct packed {
    logic clk_level;
    logic sync_level;
    logic last;
  } beat_ctrl_t;

endpackage

FILE: rtl/gps_lane.sv
module gps_lane (
  input  logic                     clk,
  input  logic [gps_pkg::POS_W-1:0] pos,
  input  logic                     signed_mode,
  input  logic                     load,
  input  logic                     shift,
  output logic                     frame_bit
);
  import gps_pkg::*;

  logic [POS_W-1:0]      value;
  logic                  parity;
  logic [FRAME_BITS-1:0] frame_r;
  logic [FRAME_BITS-1:0] frame_nxt;

  // offset binary in signed mode, parity makes the ones count of the whole frame even
  assign value  = signed_mode ? POS_W'(pos + SIGN_OFFSET) : pos;
  assign parity = ~(^value);

  // frame shift register, msb goes out first
  always_comb begin
    frame_nxt = frame_r;
    if (load) begin
      frame_nxt = {FRAME_HEADER, value, parity};
    end else if (shift) begin
      frame_nxt = {frame_r[FRAME_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frame_bit = frame_r[FRAME_BITS-1];

endmodule

FILE: rtl/gps_merge.sv
module gps_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  gps_pkg::beat_ctrl_t ctrl,
  input  logic                ch1_bit,
  input  logic                ch2_bit,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output gps_pkg::out_item_t  out_item
);
  import gps_pkg::*;

  logic [3:0] pos_pins;
  logic       valid_r;
  logic       valid_nxt;
  out_item_t  item_r;
  out_item_t  item_nxt;

  // positive pins in the low nibble, complements above
  assign pos_pins = {ch2_bit, ch1_bit, ctrl.sync_level, ctrl.clk_level};
  assign can_load = !valid_r || out_ready;

  // output register
  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt           = 1'b1;
      item_nxt.pin_levels = {~pos_pins, pos_pins};
      item_nxt.last       = ctrl.last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

FILE: rtl/galvo_position_serializer_top.sv
// Galvo position serializer: turns one X/Y position pair into the pin
// sequence of a two-channel galvo link (clock, sync, channel 1, channel 2,
// each with its complement on the upper nibble).
// Input channel: in_valid/in_ready with in_item carrying both positions.
// Result channel: out_valid/out_ready with out_item; each item gives 40
// pin bytes, two per frame bit (clock high, then clock low), last set on
// the fortieth.
// Configuration: cfg_we writes cfg_data into the signed mode flag; in
// signed mode each position is offset by 32768 before framing. Write it
// only while the block is idle.
// Timing: after acceptance the sequencer's busy and beat registers are set,
// then the first byte enters the output register. One byte per cycle while
// the receiver does not stall, paced by the 40-beat frame sequencer; the
// next item is taken in the cycle the previous item's last byte enters
// the output register, so frames follow without a gap.
// A stalled receiver holds the output register and freezes the sequencer
// and both lane shift registers; nothing is dropped.
// Reset clears the signed mode flag, the sequencer and the output valid.
module galvo_position_serializer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  gps_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output gps_pkg::out_item_t out_item
);
  import gps_pkg::*;

  logic              signed_r;
  logic              busy_r;
  logic              busy_nxt;
  logic [BEAT_W-1:0] beat_r;
  logic [BEAT_W-1:0] beat_nxt;
  logic              can_load;
  logic              emit;
  logic              last_beat;
  logic              accept;
  logic              shift;
  logic              ch1_bit;
  logic              ch2_bit;
  beat_ctrl_t        ctrl;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r <= 1'b0;
    end else if (cfg_we) begin
      signed_r <= cfg_data;
    end
  end

  // beat sequencer
  assign emit      = busy_r && can_load;
  assign last_beat = beat_r == LAST_BEAT;
  assign in_ready  = !busy_r || (emit && last_beat);
  assign accept    = in_valid && in_ready;
  assign shift     = emit && beat_r[0];

  always_comb begin
    busy_nxt = busy_r;
    beat_nxt = beat_r;
    if (accept) begin
      busy_nxt = 1'b1;
      beat_nxt = '0;
    end else if (emit) begin
      beat_nxt = beat_r + 1'b1;
      if (last_beat) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      beat_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      beat_r <= beat_nxt;
    end
  end

  // per-beat levels: clock high on even beats, sync low during parity
  assign ctrl.clk_level  = ~beat_r[0];
  assign ctrl.sync_level = beat_r < PARITY_BEAT;
  assign ctrl.last       = last_beat;

  // one lane per channel
  gps_lane u_lane_x (
    .clk         (clk),
    .pos         (in_item.x_position),
    .signed_mode (signed_r),
    .load        (accept),
    .shift       (shift),
    .frame_bit   (ch1_bit)
  );

  gps_lane u_lane_y (
    .clk         (clk),
    .pos         (in_item.y_position),
    .signed_mode (signed_r),
    .load        (accept),
    .shift       (shift),
    .frame_bit   (ch2_bit)
  );

  // merge lanes into the pin byte
  gps_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .ctrl      (ctrl),
    .ch1_bit   (ch1_bit),
    .ch2_bit   (ch2_bit),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: sim/tb_galvo_position_serializer_top.sv
module tb_galvo_position_serializer_top;
  import gps_pkg::*;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // local copy of the signed mode flag, and the pin bytes still owed
  logic      signed_mode = 1'b0;
  out_item_t expected_pins[$];
  int        mismatch_count = 0;
  // random idling on both sides, and a receiver hold-off request in cycles
  bit        stall_enable = 1'b1;
  int        hold_request = 0;

  galvo_position_serializer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_galvo_position_serializer_top NOT OK");
    $finish;
  end

  // 20-bit channel frame: header 001, position, even parity over the whole frame
  function automatic logic [FRAME_BITS-1:0] galvo_frame(logic [POS_W-1:0] pos);
    logic parity;
    parity = ^{FRAME_HEADER, pos};
    return {FRAME_HEADER, pos, parity};
  endfunction

  // one pin byte: clock, sync, channel 1, channel 2 on the low nibble, complements above
  function automatic logic [PIN_W-1:0] pin_byte(logic clk_lvl, logic sync_lvl,
                                                logic ch1, logic ch2);
    logic [3:0] lo;
    lo = {ch2, ch1, sync_lvl, clk_lvl};
    return {~lo, lo};
  endfunction

  // expected 40 pin bytes for one accepted position pair
  function automatic void predict_pin_sequence(in_item_t item);
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic [FRAME_BITS-1:0] frame_x;
    logic [FRAME_BITS-1:0] frame_y;
    out_item_t             pins;
    int                    bit_idx;
    x = item.x_position;
    y = item.y_position;
    if (signed_mode) begin
      x = x + SIGN_OFFSET;
      y = y + SIGN_OFFSET;
    end
    frame_x = galvo_frame(x);
    frame_y = galvo_frame(y);
    for (int k = 0; k < FRAME_BITS; k++) begin
      bit_idx = FRAME_BITS - 1 - k;
      // clock high half, then clock low half; sync drops for the parity bit
      pins.pin_levels = pin_byte(1'b1, bit_idx != 0, frame_x[bit_idx], frame_y[bit_idx]);
      pins.last = 1'b0;
      expected_pins.push_back(pins);
      pins.pin_levels = pin_byte(1'b0, bit_idx != 0, frame_x[bit_idx], frame_y[bit_idx]);
      pins.last = (bit_idx == 0);
      expected_pins.push_back(pins);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        $error("unexpected pin byte %02h last %0b", out_item.pin_levels, out_item.last);
        mismatch_count++;
      end else begin
        want = expected_pins.pop_front();
        if (out_item.pin_levels !== want.pin_levels) begin
          $error("pin_levels expected %02h actual %02h", want.pin_levels, out_item.pin_levels);
          mismatch_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, out_item.last);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_enable) begin
        out_ready <= ($urandom_range(99) >= 22);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one position pair and wait for it to be taken; called at a falling edge
  task automatic send_position(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    in_item_t item;
    item.x_position = x;
    item.y_position = y;
    if (stall_enable && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 22);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pin_sequence(item);
    @(negedge clk);
  endtask

  // wait until every expected byte has come out, plus the pipeline depth
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_signed_mode(logic value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    signed_mode = value;
  endtask

  // mostly random positions, with the range ends mixed in
  function automatic logic [POS_W-1:0] random_position();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      3:       return 16'h7fff;
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic test_unsigned_extremes();
    write_signed_mode(1'b0);
    send_position(16'h0000, 16'h0000);
    send_position(16'hffff, 16'hffff);
    send_position(16'h0000, 16'hffff);
    send_position(16'hffff, 16'h0000);
    send_position(16'h8000, 16'h7fff);
    send_position(16'h0001, 16'h8000);
    send_position(16'haaaa, 16'h5555);
    // odd and even weight values to flip the parity bit
    send_position(16'h0007, 16'h0003);
    send_position(16'h1234, 16'hfedc);
    wait_for_drain();
  endtask

  task automatic test_signed_offset();
    write_signed_mode(1'b1);
    send_position(16'h8000, 16'h8000);
    send_position(16'h7fff, 16'h7fff);
    send_position(16'h0000, 16'hffff);
    send_position(16'hffff, 16'h0001);
    send_position(16'h8001, 16'h7ffe);
    send_position(16'h5555, 16'haaaa);
    wait_for_drain();
  endtask

  task automatic test_random_positions(logic mode, int count);
    write_signed_mode(mode);
    repeat (count) send_position(random_position(), random_position());
    wait_for_drain();
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_receiver_hold_off();
    write_signed_mode(1'b0);
    stall_enable = 1'b0;
    hold_request = 300;
    repeat (8) send_position(random_position(), random_position());
    wait_for_drain();
    stall_enable = 1'b1;
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    write_signed_mode(1'b1);
    stall_enable = 1'b0;
    repeat (30) send_position(random_position(), random_position());
    wait_for_drain();
    stall_enable = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    signed_mode = 1'b0;
    @(negedge clk);
    test_unsigned_extremes();
    test_signed_offset();
    test_random_positions(1'b0, 35);
    test_receiver_hold_off();
    test_random_positions(1'b1, 35);
    test_back_to_back();
    test_random_positions(1'b0, 10);
    if (mismatch_count == 0) begin
      $display("tb_galvo_position_serializer_top OK");
    end else begin
      $display("tb_galvo_position_serializer_top NOT OK");
    end
    $finish;
  end

endmodule
